FILE: rtl/core/kmpoc_pkg.sv
package kmpoc_pkg;

   localparam int MAX_PATTERN_DEF = 256;

   localparam int SYM_W      = 8;
   localparam int CMD_W      = 2;
   localparam int COUNT_W    = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;
   // result fields take 4 bits, the rest of the byte is zero
   localparam int RSP_PAD_W  = RSP_DATA_W - 4;

   localparam logic [COUNT_W-1:0] COUNT_SAT = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_PATTERN = 2'd1,
      CMD_TEXT    = 2'd2
   } cmd_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic             clear;
      logic             load;
      logic             step;
      logic [SYM_W-1:0] symbol;
   } cell_ctl_type;

endpackage

FILE: rtl/core/kmpoc_cell.sv
module kmpoc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  kmpoc_pkg::cell_ctl_type ctl,
   input  logic                   prev_valid,
   input  logic                   prev_match,
   input  logic                   next_valid,
   output logic                   valid,
   output logic                   match,
   output logic                   hit
);

   logic                        valid_ff, valid_in;
   logic                        match_ff, match_in;
   logic                        hit_ff, hit_in;
   logic [kmpoc_pkg::SYM_W-1:0] sym_ff, sym_in;

   always_comb begin
      valid_in = valid_ff;
      match_in = match_ff;
      hit_in   = hit_ff;
      sym_in   = sym_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
         match_in = 1'b0;
      end else if (ctl.load) begin
         // the first empty cell takes the pattern byte
         if (prev_valid && !valid_ff) begin
            valid_in = 1'b1;
            sym_in   = ctl.symbol;
         end
      end else if (ctl.step) begin
         // extend the neighbour's prefix by one byte; empty cells stay clear
         match_in = valid_ff & prev_match & (sym_ff == ctl.symbol);
         hit_in   = match_in & ~next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      hit_ff <= hit_in;
      sym_ff <= sym_in;
   end

   assign valid = valid_ff;
   assign match = match_ff;
   assign hit   = hit_ff;

endmodule

FILE: rtl/core/kmp_occurrence_counter.sv
// channel  direction  tdata (low bit up)                               tuser
// req      in         symbol[7:0]                                      cmd[1:0]
// rsp      out        match_here, match_count[1:0], pattern_overflow,  -
//                     zero pad to 8 bits
//
// Every item is handled in two steps: when it is accepted, each cell of the chain
// compares its pattern byte and hands its match bit to the next cell; in the
// evaluation state the cell hit bits are reduced and the result register is loaded.
// Reset is synchronous; a clear command empties the chain when it is accepted.
// A stalled result holds in the output register; one further item may be
// accepted and waits in the chain until the register frees.
module kmp_occurrence_counter #(
   parameter int MAX_PATTERN = kmpoc_pkg::MAX_PATTERN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kmpoc_pkg::REQ_DATA_W-1:0] req_tdata,  // symbol[7:0]
   input  logic [kmpoc_pkg::CMD_W-1:0]      req_tuser,  // cmd[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // match_here, match_count[1:0], pattern_overflow, pad
   output logic [kmpoc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   state_type                             state_ff, state_in;
   kmpoc_pkg::cmd_type                    cmd_ff, cmd_in;
   logic                                  ovf_ff, ovf_in;
   logic [kmpoc_pkg::COUNT_W-1:0]         count_ff, count_in, count_next;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [kmpoc_pkg::RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   kmpoc_pkg::cell_ctl_type               ctl;
   kmpoc_pkg::cmd_type                    req_cmd;
   logic                                  req_accept;
   logic                                  rsp_free;
   logic                                  eval_done;
   logic                                  hit;
   logic                                  text_hit;
   logic [MAX_PATTERN-1:0]                cell_valid;
   logic [MAX_PATTERN-1:0]                cell_match;
   logic [MAX_PATTERN-1:0]                cell_hit;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic prev_valid, prev_match, next_valid;
      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_match = 1'b1;
      end else begin : g_body
         assign prev_valid = cell_valid[i-1];
         assign prev_match = cell_match[i-1];
      end
      if (i == MAX_PATTERN - 1) begin : g_tail
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_valid = cell_valid[i+1];
      end
      kmpoc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (prev_valid),
         .prev_match (prev_match),
         .next_valid (next_valid),
         .valid      (cell_valid[i]),
         .match      (cell_match[i]),
         .hit        (cell_hit[i])
      );
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      req_accept = req_tvalid & req_tready;
      req_cmd    = kmpoc_pkg::cmd_type'(req_tuser);

      ctl        = '0;
      ctl.symbol = req_tdata[kmpoc_pkg::SYM_W-1:0];
      if (req_accept) begin
         case (req_cmd)
            kmpoc_pkg::CMD_CLEAR: begin
               ctl.clear = 1'b1;
            end
            kmpoc_pkg::CMD_PATTERN: begin
               ctl.load = 1'b1;
            end
            kmpoc_pkg::CMD_TEXT: begin
               ctl.step = 1'b1;
            end
            default: begin
            end
         endcase
      end

      rsp_free  = ~rsp_valid_ff | rsp_tready;
      eval_done = (state_ff == ST_EVAL) & rsp_free;

      // an empty pattern matches at every text byte
      hit      = ~cell_valid[0] | (|cell_hit);
      text_hit = (cmd_ff == kmpoc_pkg::CMD_TEXT) & hit;

      count_next = count_ff;
      if (text_hit && count_ff < kmpoc_pkg::COUNT_SAT) begin
         count_next = count_ff + 2'd1;
      end

      cmd_in   = req_accept ? req_cmd : cmd_ff;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      if (req_accept && req_cmd == kmpoc_pkg::CMD_CLEAR) begin
         ovf_in   = 1'b0;
         count_in = '0;
      end else if (req_accept && req_cmd == kmpoc_pkg::CMD_PATTERN
                   && cell_valid[MAX_PATTERN-1]) begin
         ovf_in = 1'b1;
      end else if (eval_done) begin
         count_in = count_next;
      end

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (eval_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{kmpoc_pkg::RSP_PAD_W{1'b0}}, ovf_ff, count_next, text_hit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ovf_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ovf_ff       <= ovf_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // cells fill from the head: no loaded cell after an empty one
   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("pattern cells not filled in order");

   // a match bit never sits in an empty cell
   a_match_in_pattern: assert property (@(posedge clock) disable iff (reset)
      (cell_match & ~cell_valid) == '0)
      else $error("match bit outside the pattern");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kmpoc_pkg::COUNT_SAT)
      else $error("occurrence count beyond saturation");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EVAL)
      else $error("accepted transaction not evaluated");

   a_eval_to_rsp: assert property (@(posedge clock) disable iff (reset)
      eval_done |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("evaluated transaction produced no result");
`endif

endmodule
